/* design/multi_queue_shared_buffer_assert.svh */
// Assertion macros for the shared-buffer queue block.
// Each macro takes a label, the clock, the active-low reset, a condition
// and the property that must follow from it.
`ifndef MULTI_QUEUE_SHARED_BUFFER_ASSERT_SVH
`define MULTI_QUEUE_SHARED_BUFFER_ASSERT_SVH

`ifndef SYNTHESIS

// The consequence must hold in the same cycle as the condition.
`define MQSB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in multi_queue_shared_buffer");

// The consequence must hold in the cycle after the condition.
`define MQSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in multi_queue_shared_buffer");

`else

`define MQSB_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define MQSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* design/mqsb_pkg.sv */
package mqsb_pkg;

    localparam int DATA_W = 32;

    // Queue operation requested by an item.
    typedef enum logic {
        ACTION_ENQ = 1'b0,
        ACTION_DEQ = 1'b1
    } t_action;

    // Result status of an item.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    typedef logic signed [DATA_W-1:0] t_data;

    localparam t_data DATA_EMPTY = -32'sd1;
    localparam t_data DATA_ZERO  = 32'sd0;

endpackage

/* design/mqsb_in_if.sv */
interface mqsb_in_if
    import mqsb_pkg::*;
;
    logic       valid;
    logic       ready;
    t_action    action;
    logic [1:0] queue_id;
    t_data      data_in;

    modport source (output valid, output action, output queue_id, output data_in,
                    input ready);
    modport sink (input valid, input action, input queue_id, input data_in,
                  output ready);
endinterface

/* design/mqsb_out_if.sv */
interface mqsb_out_if
    import mqsb_pkg::*;
;
    logic    valid;
    logic    ready;
    t_data   data_out;
    t_status status;

    modport source (output valid, output data_out, output status, input ready);
    modport sink (input valid, input data_out, input status, output ready);
endinterface

/* design/multi_queue_shared_buffer.sv */
// Channel   Direction  Handshake      Payload
// i_in      in         valid/ready    action, queue_id, data_in
// o_out     out        valid/ready    data_out, status
//
// An item is taken into an input register, processed combinationally against the
// queue pointers and the link store, and its result lands in the output register.
// One item per cycle is sustained while the output is not stalled.
// Reset (synchronous, active low) empties every queue and chains all slots on the free list.
// A stalled output holds the input register, and the input stalls only once that is full.
`include "multi_queue_shared_buffer_assert.svh"

module multi_queue_shared_buffer
    import mqsb_pkg::*;
#(
    parameter int NUM_SLOTS  = 16,
    parameter int NUM_QUEUES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mqsb_in_if.sink     i_in,
    mqsb_out_if.source  o_out
);

    localparam int PW = $clog2(NUM_SLOTS + 1);
    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam logic [PW-1:0] PTR_NONE = '1;

    typedef logic [PW-1:0] t_ptr;

    function automatic logic ptr_valid(input t_ptr p);
        return p < PW'(NUM_SLOTS);
    endfunction

    // Queue numbers past the last queue wrap round.
    function automatic logic [QW-1:0] wrap_queue(input logic [1:0] id);
        int v;
        v = int'(id);
        for (int k = 0; k < 3; k++) begin
            if (v >= NUM_QUEUES) begin
                v = v - NUM_QUEUES;
            end
        end
        return QW'(v);
    endfunction

    // Input register
    logic          r_in_valid;
    t_action       r_in_action;
    logic [1:0]    r_in_queue;
    t_data         r_in_data;

    // Output register
    logic          r_out_valid;
    t_data         r_out_data;
    t_status       r_out_status;

    // Queue state
    t_ptr          r_free;
    t_ptr          r_head [NUM_QUEUES];
    t_ptr          r_tail [NUM_QUEUES];
    t_ptr          r_link [NUM_SLOTS];
    t_data         r_mem  [NUM_SLOTS];

    logic          w_advance;
    logic [QW-1:0] w_q;
    t_ptr          w_head_q;
    t_ptr          w_tail_q;
    logic          w_is_enq;
    t_ptr          w_slot;
    logic          w_slot_ok;
    t_ptr          w_link_rd;
    t_ptr          n_free;
    t_ptr          n_head;
    logic          w_link_we;
    logic [IW-1:0] w_link_wa;
    t_ptr          w_link_wd;
    t_status       n_status;

    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;

    assign o_out.valid    = r_out_valid;
    assign o_out.data_out = r_out_data;
    assign o_out.status   = r_out_status;

    always_comb begin
        w_q       = wrap_queue(r_in_queue);
        w_head_q  = r_head[w_q];
        w_tail_q  = r_tail[w_q];
        w_is_enq  = (r_in_action == ACTION_ENQ);
        w_slot    = w_is_enq ? r_free : w_head_q;
        w_slot_ok = ptr_valid(w_slot);
        w_link_rd = r_link[w_slot[IW-1:0]];

        n_free    = r_free;
        n_head    = w_head_q;
        w_link_we = 1'b0;
        w_link_wa = w_slot[IW-1:0];
        w_link_wd = r_free;
        n_status  = STATUS_OK;

        if (w_is_enq) begin
            if (w_slot_ok) begin
                n_free = ptr_valid(w_link_rd) ? w_link_rd : PTR_NONE;
                if (!ptr_valid(w_head_q)) begin
                    n_head = w_slot;
                end else if (ptr_valid(w_tail_q)) begin
                    w_link_we = 1'b1;
                    w_link_wa = w_tail_q[IW-1:0];
                    w_link_wd = w_slot;
                end
            end else begin
                n_status = STATUS_FULL;
            end
        end else begin
            if (w_slot_ok) begin
                // The tail slot is the last one; its link is never cleared.
                n_head    = ((w_slot == w_tail_q) || !ptr_valid(w_link_rd)) ?
                            PTR_NONE : w_link_rd;
                w_link_we = 1'b1;
                n_free    = w_slot;
            end else begin
                n_status = STATUS_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_free      <= '0;
            for (int k = 0; k < NUM_QUEUES; k++) begin
                r_head[k] <= PTR_NONE;
                r_tail[k] <= PTR_NONE;
            end
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_link[k] <= (k == NUM_SLOTS - 1) ? PTR_NONE : PW'(k + 1);
            end
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_advance) begin
                r_free      <= n_free;
                r_head[w_q] <= n_head;
                if (w_is_enq && w_slot_ok) begin
                    r_tail[w_q] <= w_slot;
                end
                if (w_link_we) begin
                    r_link[w_link_wa] <= w_link_wd;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_in_action <= i_in.action;
            r_in_queue  <= i_in.queue_id;
            r_in_data   <= i_in.data_in;
        end
        if (w_advance) begin
            if (w_is_enq && w_slot_ok) begin
                r_mem[w_slot[IW-1:0]] <= r_in_data;
            end
            if (!w_is_enq && w_slot_ok) begin
                r_out_data <= r_mem[w_slot[IW-1:0]];
            end else if (!w_is_enq) begin
                r_out_data <= DATA_EMPTY;
            end else begin
                r_out_data <= DATA_ZERO;
            end
            r_out_status <= n_status;
        end
    end

    `MQSB_ASSERT_NEXT(a_full_status, i_clk, i_rst_n,
        w_advance && w_is_enq && !ptr_valid(r_free),
        r_out_valid && r_out_status == STATUS_FULL && r_out_data == DATA_ZERO)
    `MQSB_ASSERT_NEXT(a_empty_status, i_clk, i_rst_n,
        w_advance && !w_is_enq && !ptr_valid(w_head_q),
        r_out_status == STATUS_EMPTY && r_out_data == DATA_EMPTY)
    `MQSB_ASSERT_NEXT(a_tail_update, i_clk, i_rst_n,
        w_advance && w_is_enq && w_slot_ok,
        r_tail[$past(w_q)] == $past(w_slot))
    `MQSB_ASSERT_NEXT(a_deq_frees_slot, i_clk, i_rst_n,
        w_advance && !w_is_enq && w_slot_ok,
        r_free == $past(w_slot))
    `MQSB_ASSERT_NOW(a_held_when_full, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !o_out.ready,
        !i_in.ready && !w_advance)

endmodule
